// File: hdl/sbk_pkg.sv
package sbk_pkg;

	localparam int KEY_W = 32;
	localparam int TAG_W = 6;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [TAG_W-1:0]        tag;
	} entry_t;

	typedef struct packed {
		logic vld;
		logic first;
	} scan_ctl_t;

endpackage

// File: hdl/sbk_in_if.sv
interface sbk_in_if;
	import sbk_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [KEY_W-1:0] key_value;
	logic                    batch_end;

	modport source (output valid, key_value, batch_end, input ready);
	modport sink (input valid, key_value, batch_end, output ready);

endinterface

// File: hdl/sbk_out_if.sv
interface sbk_out_if;
	import sbk_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [KEY_W-1:0] sorted_key;
	logic [TAG_W-1:0]        origin_index;
	logic                    final_rank;
	logic                    dropped_items;

	modport source (output valid, sorted_key, origin_index, final_rank, dropped_items,
		input ready);
	modport sink (input valid, sorted_key, origin_index, final_rank, dropped_items,
		output ready);

endinterface

// File: hdl/sbk_mem.sv
module sbk_mem #(
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  sbk_pkg::entry_t  wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output sbk_pkg::entry_t  rdata
);
	import sbk_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/sbk_minfind.sv
module sbk_minfind #(
	parameter int IW = 6
) (
	input  logic               clk,
	input  sbk_pkg::scan_ctl_t ctl,
	input  logic [IW-1:0]      idx,
	input  sbk_pkg::entry_t    rdata,
	output sbk_pkg::entry_t    cur,
	output sbk_pkg::entry_t    best,
	output logic [IW-1:0]      best_idx
);
	import sbk_pkg::*;

	entry_t        cur_q;
	entry_t        best_q;
	logic [IW-1:0] best_idx_q;

	// Only a strictly smaller key replaces the minimum, so the first of equal keys wins.
	always_ff @(posedge clk) begin
		if (ctl.vld) begin
			if (ctl.first) begin
				cur_q      <= rdata;
				best_q     <= rdata;
				best_idx_q <= idx;
			end else if ($signed(rdata.key) < $signed(best_q.key)) begin
				best_q     <= rdata;
				best_idx_q <= idx;
			end
		end
	end

	assign cur      = cur_q;
	assign best     = best_q;
	assign best_idx = best_idx_q;

endmodule

// File: hdl/selection_sort_by_key_top.sv
// Channel  Modport  Payload                                               Request
// keys     sink     key_value, batch_end                                  one key to load
// sorted   source   sorted_key, origin_index, final_rank, dropped_items   one ranked key
//
// Keys are written to the memory as they are accepted in the load phase. Sorting a batch
// runs in passes: each pass streams the unsorted tail through the single memory read port
// and then writes the swap in ST_SWAP_B and ST_SWAP_I, as the memory has one write port.
// Each result then goes through a memory read followed by the result register load.
// Reset clears the fill count, the overflow flag and the sequencer; the key memory is not
// cleared. A stalled result holds in its register; keys are refused outside the load phase.
module selection_sort_by_key_top #(
	parameter int CAPACITY = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	sbk_in_if.sink     keys,
	sbk_out_if.source  sorted
);
	import sbk_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] FULL = CW'(CAPACITY);

	localparam logic [2:0] ST_LOAD    = 3'd0;
	localparam logic [2:0] ST_SCAN    = 3'd1;
	localparam logic [2:0] ST_SWAP_B  = 3'd2;
	localparam logic [2:0] ST_SWAP_I  = 3'd3;
	localparam logic [2:0] ST_EMIT_RD = 3'd4;
	localparam logic [2:0] ST_EMIT_LD = 3'd5;

	logic [2:0]    state_q;
	logic [CW-1:0] fill_q;
	logic          ovf_q;
	logic [IW-1:0] pos_q;
	logic [CW-1:0] iss_q;
	logic [IW-1:0] emit_q;
	logic          rv_s1;
	logic [IW-1:0] ridx_s1;
	logic          res_valid_q;
	entry_t        res_q;
	logic          res_final_q;
	logic          res_drop_q;

	logic          in_acc;
	logic          has_room;
	logic [CW-1:0] fill_inc;
	logic [CW-1:0] fill_m1;
	logic [IW-1:0] last_idx;
	logic          issuing;
	logic          emit_go;
	logic          emit_last;
	logic          more_passes;

	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	entry_t        mem_wdata;
	logic          mem_re;
	logic [IW-1:0] mem_raddr;
	entry_t        mem_rdata;

	scan_ctl_t     scan_ctl;
	entry_t        cur;
	entry_t        best;
	logic [IW-1:0] best_idx;

	assign keys.ready  = (state_q == ST_LOAD);
	assign in_acc      = keys.valid && keys.ready;
	assign has_room    = fill_q < FULL;
	assign fill_inc    = fill_q + CW'(1);
	assign fill_m1     = fill_q - CW'(1);
	assign last_idx    = fill_m1[IW-1:0];
	assign issuing     = iss_q < fill_q;
	assign emit_go     = !res_valid_q || sorted.ready;
	assign emit_last   = (emit_q == last_idx);
	assign more_passes = (CW'(pos_q) + CW'(2)) < fill_q;

	assign scan_ctl.vld   = rv_s1;
	assign scan_ctl.first = (ridx_s1 == pos_q);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = fill_q[IW-1:0];
		mem_wdata = '{key: keys.key_value, tag: TAG_W'(fill_q)};
		mem_re    = 1'b0;
		mem_raddr = iss_q[IW-1:0];
		unique case (state_q)
			ST_LOAD: begin
				mem_we = in_acc && has_room;
			end
			ST_SCAN: begin
				mem_re = issuing;
			end
			ST_SWAP_B: begin
				mem_we    = 1'b1;
				mem_waddr = best_idx;
				mem_wdata = cur;
			end
			ST_SWAP_I: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q;
				mem_wdata = best;
			end
			ST_EMIT_RD: begin
				mem_re    = emit_go;
				mem_raddr = emit_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			fill_q      <= '0;
			ovf_q       <= 1'b0;
			pos_q       <= '0;
			iss_q       <= '0;
			emit_q      <= '0;
			rv_s1       <= 1'b0;
			ridx_s1     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			rv_s1   <= (state_q == ST_SCAN) && issuing;
			ridx_s1 <= iss_q[IW-1:0];
			if (state_q == ST_EMIT_LD) begin
				res_valid_q <= 1'b1;
			end else if (sorted.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (has_room) begin
							fill_q <= fill_inc;
						end else begin
							ovf_q <= 1'b1;
						end
						if (keys.batch_end) begin
							pos_q  <= '0;
							iss_q  <= '0;
							emit_q <= '0;
							if ((has_room ? fill_inc : fill_q) > CW'(1)) begin
								state_q <= ST_SCAN;
							end else begin
								state_q <= ST_EMIT_RD;
							end
						end
					end
				end
				ST_SCAN: begin
					if (issuing) begin
						iss_q <= iss_q + CW'(1);
					end
					if (rv_s1 && ridx_s1 == last_idx) begin
						state_q <= ST_SWAP_B;
					end
				end
				ST_SWAP_B: begin
					state_q <= ST_SWAP_I;
				end
				ST_SWAP_I: begin
					pos_q <= pos_q + IW'(1);
					iss_q <= CW'(pos_q) + CW'(1);
					if (more_passes) begin
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_EMIT_RD;
					end
				end
				ST_EMIT_RD: begin
					if (emit_go) begin
						state_q <= ST_EMIT_LD;
					end
				end
				ST_EMIT_LD: begin
					if (emit_last) begin
						fill_q  <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_LOAD;
					end else begin
						emit_q  <= emit_q + IW'(1);
						state_q <= ST_EMIT_RD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT_LD) begin
			res_q       <= mem_rdata;
			res_final_q <= emit_last;
			res_drop_q  <= ovf_q;
		end
	end

	assign sorted.valid         = res_valid_q;
	assign sorted.sorted_key    = res_q.key;
	assign sorted.origin_index  = res_q.tag;
	assign sorted.final_rank    = res_final_q;
	assign sorted.dropped_items = res_drop_q;

	sbk_mem #(
		.DEPTH (CAPACITY)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	sbk_minfind #(
		.IW (IW)
	) u_minfind (
		.clk      (clk),
		.ctl      (scan_ctl),
		.idx      (ridx_s1),
		.rdata    (mem_rdata),
		.cur      (cur),
		.best     (best),
		.best_idx (best_idx)
	);

endmodule

// File: hdl/sbk_check.sv
module sbk_check (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic signed [sbk_pkg::KEY_W-1:0] sorted_key,
	input logic                             final_rank,
	input logic                             dropped_items
);
	import sbk_pkg::*;

	logic                    out_acc;
	logic                    mid_q;
	logic signed [KEY_W-1:0] prev_key_q;
	logic                    prev_drop_q;

	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q <= 1'b0;
		end else if (out_acc) begin
			mid_q <= !final_rank;
		end
	end

	always_ff @(posedge clk) begin
		if (out_acc) begin
			prev_key_q  <= sorted_key;
			prev_drop_q <= dropped_items;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result request withdrawn before it was taken");

	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && mid_q |-> sorted_key >= prev_key_q)
		else $error("results of a batch are not in ascending key order");

	a_drop_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && mid_q |-> dropped_items == prev_drop_q)
		else $error("overflow mark changed within a batch");

	a_no_load_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !final_rank |-> !in_ready)
		else $error("keys taken while a batch is still being delivered");

endmodule

bind selection_sort_by_key_top sbk_check u_sbk_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (keys.ready),
	.out_valid     (sorted.valid),
	.out_ready     (sorted.ready),
	.sorted_key    (sorted.sorted_key),
	.final_rank    (sorted.final_rank),
	.dropped_items (sorted.dropped_items)
);

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import sbk_pkg::*;

	localparam int CAP = 64;
	localparam int RANDOM_KEYS = 460;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 600;
	localparam int DRAIN_CYCLES = 200;

	typedef logic signed [KEY_W-1:0] key_t;

	typedef struct packed {
		key_t             key;
		logic [TAG_W-1:0] tag;
		logic             fin;
		logic             drop;
	} ranked_t;

	typedef struct packed {
		key_t    key;
		logic    last;
		logic    typed;
		ranked_t want;
	} stim_row_t;

	typedef enum {SPREAD_FULL, SPREAD_CLUSTER, SPREAD_EXTREME, SPREAD_NEAR} key_spread_t;

	localparam key_t KEY_MAX = 32'sh7FFFFFFF;
	localparam key_t KEY_MIN = 32'sh80000000;
	localparam key_t KEY_ONES = 32'shFFFFFFFF;
	localparam ranked_t NO_WANT = '0;

	logic clk;
	logic arst_n = 1'b0;

	sbk_in_if  keys_ch ();
	sbk_out_if ranks_ch ();

	selection_sort_by_key_top #(
		.CAPACITY(CAP)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.keys  (keys_ch),
		.sorted(ranks_ch)
	);

	// Single-key batches carry their result in the row; the rest go through the ranking model.
	stim_row_t directed_rows[19] = '{
		'{KEY_MAX, 1'b1, 1'b1, '{KEY_MAX, 6'd0, 1'b1, 1'b0}},
		'{KEY_MIN, 1'b1, 1'b1, '{KEY_MIN, 6'd0, 1'b1, 1'b0}},
		'{32'sh0, 1'b1, 1'b1, '{32'sh0, 6'd0, 1'b1, 1'b0}},
		'{KEY_ONES, 1'b1, 1'b1, '{KEY_ONES, 6'd0, 1'b1, 1'b0}},
		'{KEY_MAX, 1'b0, 1'b0, NO_WANT},
		'{32'sh5, 1'b0, 1'b0, NO_WANT},
		'{KEY_MIN, 1'b0, 1'b0, NO_WANT},
		'{32'sh5, 1'b0, 1'b0, NO_WANT},
		'{KEY_ONES, 1'b0, 1'b0, NO_WANT},
		'{32'sh5, 1'b0, 1'b0, NO_WANT},
		'{32'sh00010000, 1'b1, 1'b0, NO_WANT},
		'{32'sh3, 1'b0, 1'b0, NO_WANT},
		'{32'sh3, 1'b1, 1'b0, NO_WANT},
		'{32'sh00020000, 1'b0, 1'b0, NO_WANT},
		'{32'sh00018000, 1'b0, 1'b0, NO_WANT},
		'{32'shFFFF8000, 1'b0, 1'b0, NO_WANT},
		'{32'sh80000001, 1'b1, 1'b0, NO_WANT},
		'{32'shAAAAAAAA, 1'b0, 1'b0, NO_WANT},
		'{32'sh55555555, 1'b1, 1'b0, NO_WANT}
	};

	key_t extreme_keys[6] = '{KEY_MIN, KEY_MAX, 32'sh0, KEY_ONES, 32'sh80000001, 32'sh7FFFFFFE};

	key_t             held_key[CAP];
	logic [TAG_W-1:0] held_tag[CAP];
	int               held_n = 0;
	logic             lost = 1'b0;

	ranked_t due_ranks[$];
	int      results_seen = 0;
	int      fails = 0;
	int      cycle = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic bit take_break();
		return !(results_seen >= 200 && results_seen < 320) && $urandom_range(99) < 27;
	endfunction

	function automatic void load_and_rank(input key_t key, input logic last,
		output ranked_t res[$]);
		int               pick;
		key_t             low_key;
		logic [TAG_W-1:0] low_tag;
		res = {};
		if (held_n < CAP) begin
			held_key[held_n] = key;
			held_tag[held_n] = TAG_W'(held_n);
			held_n++;
		end else begin
			lost = 1'b1;
		end
		if (!last)
			return;
		for (int i = 0; i + 1 < held_n; i++) begin
			pick = i;
			low_key = held_key[i];
			low_tag = held_tag[i];
			for (int j = i + 1; j < held_n; j++) begin
				if (held_key[j] < low_key) begin
					pick = j;
					low_key = held_key[j];
					low_tag = held_tag[j];
				end
			end
			held_key[pick] = held_key[i];
			held_tag[pick] = held_tag[i];
			held_key[i] = low_key;
			held_tag[i] = low_tag;
		end
		for (int r = 0; r < held_n; r++)
			res.push_back(ranked_t'{held_key[r], held_tag[r], r == held_n - 1, lost});
		held_n = 0;
		lost = 1'b0;
	endfunction

	// Called at a falling edge; returns at the next falling edge after the request is taken.
	task automatic offer_key(input key_t key, input logic last, input logic typed,
		input ranked_t want);
		ranked_t res[$];
		while (take_break()) begin
			keys_ch.valid = 1'b0;
			@(negedge clk);
		end
		keys_ch.valid = 1'b1;
		keys_ch.key_value = key;
		keys_ch.batch_end = last;
		do @(posedge clk); while (!keys_ch.ready);
		load_and_rank(key, last, res);
		if (typed)
			res = {want};
		foreach (res[r])
			due_ranks.push_back(res[r]);
		@(negedge clk);
	endtask

	initial begin
		keys_ch.valid = 1'b0;
		keys_ch.key_value = '0;
		keys_ch.batch_end = 1'b0;
		while (cycle < CYCLE_LIMIT)
			@(posedge clk) cycle++;
		$display("selection_sort_by_key_top verification failed");
		$finish;
	end

	initial begin
		ranked_t want;
		int      hold_left;
		bit      hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		ranks_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && results_seen >= 120) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				ranks_ch.ready = 1'b0;
			end else begin
				ranks_ch.ready = !take_break();
			end
			@(posedge clk);
			if (ranks_ch.valid && ranks_ch.ready) begin
				results_seen++;
				if (due_ranks.size() == 0) begin
					$display("%0t: unexpected result: expected none, got key %0d index %0d",
						$time, ranks_ch.sorted_key, ranks_ch.origin_index);
					fails++;
				end else begin
					want = due_ranks.pop_front();
					if (ranks_ch.sorted_key !== want.key) begin
						$display("%0t: sorted_key expected %0d, got %0d",
							$time, want.key, ranks_ch.sorted_key);
						fails++;
					end
					if (ranks_ch.origin_index !== want.tag) begin
						$display("%0t: origin_index expected %0d, got %0d",
							$time, want.tag, ranks_ch.origin_index);
						fails++;
					end
					if (ranks_ch.final_rank !== want.fin) begin
						$display("%0t: final_rank expected %b, got %b",
							$time, want.fin, ranks_ch.final_rank);
						fails++;
					end
					if (ranks_ch.dropped_items !== want.drop) begin
						$display("%0t: dropped_items expected %b, got %b",
							$time, want.drop, ranks_ch.dropped_items);
						fails++;
					end
				end
			end
		end
	end

	initial begin
		int          loaded;
		int          batch_no;
		int          n;
		key_spread_t spread;
		key_t        key;
		loaded = 0;
		batch_no = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			offer_key(directed_rows[i].key, directed_rows[i].last, directed_rows[i].typed,
				directed_rows[i].want);

		// Mostly short batches; one batch fills the store exactly and one spills past it.
		while (loaded < RANDOM_KEYS) begin
			if (batch_no == 4)
				n = CAP;
			else if (batch_no == 9)
				n = CAP + $urandom_range(5, 1);
			else if ($urandom_range(99) < 80)
				n = $urandom_range(12, 1);
			else
				n = $urandom_range(40, 13);
			spread = key_spread_t'($urandom_range(3));
			for (int i = 0; i < n; i++) begin
				case (spread)
					SPREAD_FULL: key = key_t'($urandom);
					SPREAD_CLUSTER: key = key_t'(int'($urandom_range(8)) - 4);
					SPREAD_EXTREME: key = extreme_keys[$urandom_range(5)];
					default: key = key_t'(int'($urandom_range(32'h3FFFF)) - 32'sh20000);
				endcase
				offer_key(key, i == n - 1, 1'b0, NO_WANT);
			end
			loaded += n;
			batch_no++;
		end
		keys_ch.valid = 1'b0;

		while (due_ranks.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("selection_sort_by_key_top verification clean");
		else
			$display("selection_sort_by_key_top verification failed");
		$finish;
	end

endmodule
